// ===== sv/jss_pkg.sv =====
// ----------------------------------------------------------------------------
// Jacobi stencil sweep package
// Result beat type, register indexes and fixed widths of the sweep block.
// ----------------------------------------------------------------------------
package jss_pkg;

  localparam int DATA_W     = 32;
  localparam int DIM_W      = 11;
  localparam int TOL_W      = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  // largest value an 11-bit dimension register can hold
  localparam int DIM_MAX = (1 << DIM_W) - 1;

  localparam logic [DIM_W-1:0] MIN_DIM = DIM_W'(3);

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = CFG_IDX_W'(2);

  localparam logic [DIM_W-1:0] RST_GRID_WIDTH  = DIM_W'(1000);
  localparam logic [DIM_W-1:0] RST_GRID_HEIGHT = DIM_W'(1000);
  localparam logic [TOL_W-1:0] RST_TOLERANCE   = TOL_W'(66);

  localparam logic [TOL_W-1:0] MAX31 = {TOL_W{1'b1}};

  // result queue
  localparam int QDEPTH = 8;
  localparam int Q_AW   = $clog2(QDEPTH);

  typedef struct packed {
    logic [DATA_W-1:0] new_value;
    logic              is_last;
    logic [TOL_W-1:0]  max_change;
    logic              converged;
  } res_t;

endpackage

// ===== sv/jacobi_stencil_sweep.sv =====
// ----------------------------------------------------------------------------
// Jacobi stencil sweep
// Pipeline: operands are registered in stage 1, the new value in stage 2, and
//   the results are then written to the queue. Throughput: one cell per cycle
//   while each cell gives one result and the queue has room; on the last row
//   two results per cell, so the single result port limits the rate there.
//   In-ready drops after each config write while row buffer reads are reissued.
// Reset: counters, running maximum, queue and registers to defaults; the row
//   buffers are not cleared.
// One sweep of a five-point stencil over a raster stream, emitting rows one
// row behind the input, with running maximum change and convergence flag.
// ----------------------------------------------------------------------------
module jacobi_stencil_sweep #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [jss_pkg::DATA_W-1:0]    in_cell_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [jss_pkg::DATA_W-1:0]    out_new_value,
  output logic                                 out_is_last,
  output logic        [jss_pkg::TOL_W-1:0]     out_max_change,
  output logic                                 out_converged,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [jss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [jss_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int DW   = jss_pkg::DATA_W;
  localparam int TW   = jss_pkg::TOL_W;
  localparam int NW   = jss_pkg::DIM_W;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int CRW  = (CW > RW) ? CW : RW;
  localparam int XW   = ((CRW > NW) ? CRW : NW) + 1;
  localparam int WLIM = (MAX_WIDTH > jss_pkg::DIM_MAX) ? jss_pkg::DIM_MAX : MAX_WIDTH;
  localparam int HLIM = (MAX_HEIGHT > jss_pkg::DIM_MAX) ? jss_pkg::DIM_MAX : MAX_HEIGHT;
  localparam int QAW  = jss_pkg::Q_AW;
  localparam int CRDW = QAW + 2;

  typedef struct packed {
    logic [DW-1:0] x;
    logic [DW-1:0] centre;
    logic [DW-1:0] up;
    logic [DW-1:0] left;
    logic [DW-1:0] right;
    logic          emit_prev;
    logic          interior;
    logic          emit_self;
    logic          last;
  } op_t;

  typedef struct packed {
    logic [DW-1:0] v;
    logic [DW-1:0] centre;
    logic [DW-1:0] x;
    logic          emit_prev;
    logic          interior;
    logic          emit_self;
    logic          last;
  } chg_t;

  // configuration
  logic [NW-1:0] grid_width_r, grid_height_r;
  logic [TW-1:0] tolerance_r;
  logic          cfg_fire;

  // sweep position
  logic [CW-1:0] col_r, col_nxt, col_adv, c_eff, cn;
  logic [RW-1:0] row_r, row_nxt;
  logic [NW-1:0] w_eff, h_eff, wm1, hm1;
  logic [XW-1:0] wm1_x, hm1_x, col_x, row_x;
  logic          row_end, grid_end, interior;
  logic          in_fire, rd_ok_r;

  // row buffers and their read ports
  logic [DW-1:0] prev_mem  [MAX_WIDTH];
  logic [DW-1:0] prev2_mem [MAX_WIDTH];
  logic [DW-1:0] prev_rd_c_r, prev_rd_r_r, prev2_rd_c_r, prev2_rd_l_r;
  logic [CW-1:0] ra_r, ra_l;
  logic          hit_c_r, hit_r_r, hit_l_r;
  logic [DW-1:0] byp_x_r, byp_cen_r;
  logic [DW-1:0] centre_cur, right_cur, up_cur, left_cur;

  // pipeline
  op_t             s1_r;
  chg_t            s2_r;
  logic            s1_v_r, s2_v_r;
  logic [DW+1:0]   sum4;
  logic [DW-1:0]   v_sel;
  logic [DW:0]     diff, adiff;
  logic [TW-1:0]   chg, max_new, run_max_r;
  logic            conv;
  jss_pkg::res_t   res_a, res_b, res_first;
  logic [1:0]      n1, n2;

  // result queue
  jss_pkg::res_t   q_mem [jss_pkg::QDEPTH];
  logic [QAW-1:0]  wptr_r, rptr_r;
  logic [QAW:0]    cnt_r;
  logic [CRDW-1:0] cred;
  logic            pop;
  jss_pkg::res_t   head;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= jss_pkg::RST_GRID_WIDTH;
      grid_height_r <= jss_pkg::RST_GRID_HEIGHT;
      tolerance_r   <= jss_pkg::RST_TOLERANCE;
    end else if (cfg_fire) begin
      case (cfg_index)
        jss_pkg::REG_GRID_WIDTH:  grid_width_r  <= cfg_data[NW-1:0];
        jss_pkg::REG_GRID_HEIGHT: grid_height_r <= cfg_data[NW-1:0];
        jss_pkg::REG_TOLERANCE:   tolerance_r   <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  always_comb begin
    if (grid_width_r < jss_pkg::MIN_DIM)
      w_eff = jss_pkg::MIN_DIM;
    else if (grid_width_r > NW'(WLIM))
      w_eff = NW'(WLIM);
    else
      w_eff = grid_width_r;
    if (grid_height_r < jss_pkg::MIN_DIM)
      h_eff = jss_pkg::MIN_DIM;
    else if (grid_height_r > NW'(HLIM))
      h_eff = NW'(HLIM);
    else
      h_eff = grid_height_r;
  end

  assign wm1   = w_eff - NW'(1);
  assign hm1   = h_eff - NW'(1);
  assign wm1_x = XW'(wm1);
  assign hm1_x = XW'(hm1);
  assign col_x = XW'(col_r);
  assign row_x = XW'(row_r);

  // a column at or past the row end is taken as the last column
  assign row_end  = (col_x >= wm1_x);
  assign c_eff    = row_end ? wm1_x[CW-1:0] : col_r;
  assign grid_end = (row_x >= hm1_x);
  assign interior = (row_x >= XW'(2)) && (row_x <= hm1_x) &&
                    (c_eff != '0) && (XW'(c_eff) < wm1_x);

  assign in_fire = in_valid & in_ready;

  assign col_adv = row_end ? '0 : c_eff + CW'(1);
  assign col_nxt = in_fire ? col_adv : col_r;
  assign cn      = (XW'(col_nxt) >= wm1_x) ? wm1_x[CW-1:0] : col_nxt;

  always_comb begin
    row_nxt = row_r;
    if (in_fire && row_end)
      row_nxt = grid_end ? '0 : row_r + RW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      // reads issued under a changing width are stale; in-ready is held off after any configuration write
      rd_ok_r <= !cfg_fire;
    end
  end

  // row buffers: reads always target the next beat's columns
  assign ra_r = cn + CW'(1);
  assign ra_l = cn - CW'(1);

  assign centre_cur = hit_c_r ? byp_x_r   : prev_rd_c_r;
  assign right_cur  = hit_r_r ? byp_x_r   : prev_rd_r_r;
  assign up_cur     = hit_c_r ? byp_cen_r : prev2_rd_c_r;
  assign left_cur   = hit_l_r ? byp_cen_r : prev2_rd_l_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      prev_mem[c_eff]  <= in_cell_value;
      prev2_mem[c_eff] <= centre_cur;
    end
    prev_rd_c_r  <= prev_mem[cn];
    prev_rd_r_r  <= prev_mem[ra_r];
    prev2_rd_c_r <= prev2_mem[cn];
    prev2_rd_l_r <= prev2_mem[ra_l];
    hit_c_r      <= in_fire && (c_eff == cn);
    hit_r_r      <= in_fire && (c_eff == ra_r);
    hit_l_r      <= in_fire && (c_eff == ra_l);
    byp_x_r      <= in_cell_value;
    byp_cen_r    <= centre_cur;
  end

  // stage 1: operands
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.x         <= in_cell_value;
      s1_r.centre    <= centre_cur;
      s1_r.up        <= up_cur;
      s1_r.left      <= left_cur;
      s1_r.right     <= right_cur;
      s1_r.emit_prev <= (row_r != '0);
      s1_r.interior  <= interior;
      s1_r.emit_self <= grid_end;
      s1_r.last      <= grid_end & row_end;
    end
  end

  // floor of the quarter sum is an arithmetic shift of the widened sum
  assign sum4 = {{2{s1_r.up[DW-1]}},    s1_r.up}    + {{2{s1_r.x[DW-1]}},     s1_r.x} +
                {{2{s1_r.left[DW-1]}},  s1_r.left}  + {{2{s1_r.right[DW-1]}}, s1_r.right};
  assign v_sel = s1_r.interior ? sum4[DW+1:2] : s1_r.centre;

  // stage 2: new value
  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_r.v         <= v_sel;
      s2_r.centre    <= s1_r.centre;
      s2_r.x         <= s1_r.x;
      s2_r.emit_prev <= s1_r.emit_prev;
      s2_r.interior  <= s1_r.interior;
      s2_r.emit_self <= s1_r.emit_self;
      s2_r.last      <= s1_r.last;
    end
  end

  assign diff  = {s2_r.v[DW-1], s2_r.v} - {s2_r.centre[DW-1], s2_r.centre};
  assign adiff = diff[DW] ? (~diff + (DW+1)'(1)) : diff;

  always_comb begin
    if (!s2_r.interior)
      chg = '0;
    else if (adiff[DW:TW] != '0)
      chg = jss_pkg::MAX31;
    else
      chg = adiff[TW-1:0];
  end

  assign max_new = (chg > run_max_r) ? chg : run_max_r;
  assign conv    = (run_max_r <= tolerance_r) && (chg <= tolerance_r);

  always_comb begin
    res_a            = '0;
    res_a.new_value  = s2_r.v;
    res_b            = '0;
    res_b.new_value  = s2_r.x;
    res_b.is_last    = s2_r.last;
    res_b.max_change = s2_r.last ? max_new : '0;
    res_b.converged  = s2_r.last & conv;
    res_first        = s2_r.emit_prev ? res_a : res_b;
  end

  assign n1 = s1_v_r ? (2'(s1_r.emit_prev) + 2'(s1_r.emit_self)) : 2'd0;
  assign n2 = s2_v_r ? (2'(s2_r.emit_prev) + 2'(s2_r.emit_self)) : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      run_max_r <= '0;
    end else begin
      s1_v_r <= in_fire;
      s2_v_r <= s1_v_r;
      if (s2_v_r)
        run_max_r <= s2_r.last ? '0 : max_new;
    end
  end

  // result queue; input space is reserved for every beat in flight
  assign cred     = CRDW'(cnt_r) + CRDW'(n1) + CRDW'(n2);
  assign in_ready = rd_ok_r && (cred <= CRDW'(jss_pkg::QDEPTH - 2));

  assign pop       = out_valid & out_ready;
  assign out_valid = (cnt_r != '0);
  assign head      = q_mem[rptr_r];

  assign out_new_value  = head.new_value;
  assign out_is_last    = head.is_last;
  assign out_max_change = head.max_change;
  assign out_converged  = head.converged;

  always_ff @(posedge clk) begin
    if (n2 != 2'd0)
      q_mem[wptr_r] <= res_first;
    if (n2 == 2'd2)
      q_mem[wptr_r + QAW'(1)] <= res_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_r + QAW'(n2);
      if (pop)
        rptr_r <= rptr_r + QAW'(1);
      cnt_r <= cnt_r + (QAW+1)'(n2) - (QAW+1)'(pop);
    end
  end

endmodule
